[src/scla_pkg.sv]
// ----------------------------------------------------------------------------
// Scroll comment lane allocator package
// Field widths, reset values, multiplier constants, register indexes and the
// sequencer codes shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package scla_pkg;

  // Field widths
  localparam int NOW_W  = 32;
  localparam int TW_W   = 13;
  localparam int SPD_W  = 12;
  localparam int DIM_W  = 14;
  localparam int LANE_W = 6;
  localparam int SW_W   = 24;   // stored comment width, signed
  localparam int DT_W   = 21;   // saturated elapsed time

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int APB_W   = 32;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SHOW_ENABLE   = 2'd2;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 14'd1280;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 14'd720;

  // Contents of a lane that has never been written
  localparam logic [NOW_W-1:0] START_RESET = 32'hFFFE7960;
  localparam logic [SW_W-1:0]  WIDTH_RESET = 24'hF0BDC0;
  localparam logic [SPD_W-1:0] SPEED_RESET = 12'd0;

  localparam logic [DT_W-1:0] DT_MAX = 21'h100000;

  // Shared multiplier: signed A operand times unsigned B operand
  localparam int MA_W   = 38;
  localparam int MB_W   = 27;
  localparam int PROD_W = 58;
  localparam int FULL_W = MA_W + MB_W + 1;

  // 60 frames per second, 256 for the Q8 speed, 1000 ms and 1.667 ms scaled
  localparam logic [MB_W-1:0] K_FRAMES = 27'd60;
  localparam logic [MB_W-1:0] K_CENTI  = 27'd100;
  localparam logic [MB_W-1:0] K_CLEAR  = 27'd256000;
  localparam logic [MB_W-1:0] K_SAFE   = 27'd426752;

  // Reciprocal shift for the lane pitch
  localparam int PITCH_SHIFT = 21;

  // Pitch sequence steps
  localparam logic [3:0] PS_RECIP = 4'd0;
  localparam logic [3:0] PS_BACK  = 4'd1;
  localparam logic [3:0] PS_FIX   = 4'd2;

  // Lane test sequence steps
  localparam logic [3:0] SQ_DT60     = 4'd0;
  localparam logic [3:0] SQ_CS       = 4'd1;
  localparam logic [3:0] SQ_WCLR     = 4'd2;
  localparam logic [3:0] SQ_CLR_CMP  = 4'd3;
  localparam logic [3:0] SQ_DT100    = 4'd4;
  localparam logic [3:0] SQ_RATE     = 4'd5;
  localparam logic [3:0] SQ_WCS      = 4'd6;
  localparam logic [3:0] SQ_GAP      = 4'd7;
  localparam logic [3:0] SQ_SUM      = 4'd8;
  localparam logic [3:0] SQ_SCALE    = 4'd9;
  localparam logic [3:0] SQ_SAFE_CMP = 4'd10;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PITCH = 6'b000010,
    ST_READ  = 6'b000100,
    ST_TEST  = 6'b001000,
    ST_PLACE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

[src/scla_if.sv]
// ----------------------------------------------------------------------------
// Scroll comment lane allocator channels
// Valid/ready channels for comment requests and lane results.
// ----------------------------------------------------------------------------
`default_nettype none

interface scla_req_if;
  import scla_pkg::*;

  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ms;
  logic [TW_W-1:0]  text_width;
  logic [SPD_W-1:0] speed_q8;

  modport source (output valid, now_ms, text_width, speed_q8, input ready);
  modport sink (input valid, now_ms, text_width, speed_q8, output ready);
endinterface

interface scla_rsp_if;
  import scla_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [LANE_W-1:0] lane;
  logic [DIM_W-1:0]  lane_y;

  modport source (output valid, found, lane, lane_y, input ready);
  modport sink (input valid, found, lane, lane_y, output ready);
endinterface

`default_nettype wire

[src/scla_ram.sv]
// ----------------------------------------------------------------------------
// Scroll comment lane allocator RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/scroll_comment_lane_allocator.sv]
// With placement disabled an accepted word goes straight to the done state.
// Otherwise the lane pitch is worked out first, then each lane is read and put
// to the clear test and, where the new comment is faster than the one in the
// lane, to the catch-up test, all on the one shared multiplier; the first free
// lane is then written in the place state. One word is in work at a time.
// Reset restores the register defaults and marks every lane empty at once.
// ----------------------------------------------------------------------------
// Scroll comment lane allocator
// Scans lanes from the lowest and places a comment into the first lane where
// it neither overlaps nor catches the comment already running there.
// ----------------------------------------------------------------------------
`default_nettype none

module scroll_comment_lane_allocator #(
  parameter int LANES = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scla_pkg::PADDR_W-1:0] paddr,
  input  logic [scla_pkg::APB_W-1:0]   pwdata,
  output logic [scla_pkg::APB_W-1:0]   prdata,
  output logic                         pready,
  scla_req_if.sink                     req,
  scla_rsp_if.source                   rsp
);

  import scla_pkg::*;

  localparam int AW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ENT_W = NOW_W + SW_W + SPD_W;
  localparam logic [MB_W-1:0] RECIP   = MB_W'((1 << PITCH_SHIFT) / LANES);
  localparam logic [MB_W-1:0] LANES_B = MB_W'(LANES);
  localparam logic [AW-1:0]   LAST    = AW'(LANES - 1);

  // Configuration
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic             show_enable;

  // Sequencer
  state_t        state, state_next;
  logic [AW-1:0] lane, lane_next;
  logic [3:0]    step, step_next;
  logic          found_r;

  // Captured request and current lane
  logic [NOW_W-1:0]       now_r;
  logic [TW_W-1:0]        tw_r;
  logic [SPD_W-1:0]       cs_r;
  logic [DT_W-1:0]        dt_r;
  logic signed [SW_W-1:0] w_r;
  logic [SPD_W-1:0]       sp_r;

  // Shared multiplier and its holding registers
  logic signed [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]          mul_b;
  logic signed [FULL_W-1:0] mul_full;
  logic                     mul_en;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] hold;
  logic signed [MA_W-1:0]   hold2;
  logic [DIM_W-1:0]         pitch;
  logic [DIM_W-1:0]         hi_q;
  logic [DIM_W:0]           pitch_rem;
  logic                     hold_gt_prod;

  // Lane store
  logic [LANES-1:0] lane_valid;
  logic             ram_we;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic [NOW_W-1:0] start_eff;
  logic [SW_W-1:0]  w_eff;
  logic [SPD_W-1:0] sp_eff;
  logic [NOW_W-1:0] elapsed;
  logic [DT_W-1:0]  dt_sat;
  logic [SPD_W-1:0] cs_minus_sp;
  logic             cs_gt_sp;

  // Output register
  logic              out_valid;
  logic              out_found;
  logic [LANE_W-1:0] out_lane;
  logic [DIM_W-1:0]  out_lane_y;
  logic              out_load;
  logic              accept;
  logic              cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      show_enable   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[DIM_W-1:0];
        REG_SHOW_ENABLE:   show_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCREEN_WIDTH:  prdata = APB_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_W'(screen_height);
      REG_SHOW_ENABLE:   prdata = APB_W'(show_enable);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Lane store
  // --------------------------------------------------------------------------
  assign ram_we    = (state == ST_PLACE);
  assign ram_wdata = {now_r, SW_W'(tw_r), cs_r};

  // The read address follows the next lane so the data lines up with lane.
  scla_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LANES)
  ) u_lane_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lane),
    .wdata (ram_wdata),
    .raddr (lane_next),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (lane_valid[lane]) begin
      start_eff = ram_rdata[ENT_W-1 -: NOW_W];
      w_eff     = ram_rdata[SW_W+SPD_W-1 -: SW_W];
      sp_eff    = ram_rdata[SPD_W-1:0];
    end else begin
      start_eff = START_RESET;
      w_eff     = WIDTH_RESET;
      sp_eff    = SPEED_RESET;
    end
  end

  assign elapsed     = now_r - start_eff;
  assign dt_sat      = (elapsed > NOW_W'(DT_MAX)) ? DT_MAX : elapsed[DT_W-1:0];
  assign cs_gt_sp    = (cs_r > sp_r);
  assign cs_minus_sp = cs_r - sp_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= '0;
    end else if (ram_we) begin
      lane_valid[lane] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  assign hi_q         = prod[PITCH_SHIFT+DIM_W-1:PITCH_SHIFT];
  assign pitch_rem    = {1'b0, screen_height} - prod[DIM_W:0];
  assign hold_gt_prod = (hold > prod);
  assign mul_en       = (state == ST_PITCH) || (state == ST_TEST) || (state == ST_PLACE);

  // The catch-up test is folded into dt*sp*cs*100 > 426752*(w*cs + wr*(cs-sp)).
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_PITCH: begin
        case (step)
          PS_RECIP: begin
            mul_a = MA_W'(screen_height);
            mul_b = RECIP;
          end
          PS_BACK: begin
            mul_a = MA_W'(hi_q);
            mul_b = LANES_B;
          end
          default: ;
        endcase
      end
      ST_TEST: begin
        case (step)
          SQ_DT60: begin
            mul_a = MA_W'(dt_r);
            mul_b = K_FRAMES;
          end
          SQ_CS: begin
            mul_a = MA_W'(prod[MB_W-1:0]);
            mul_b = MB_W'(cs_r);
          end
          SQ_WCLR: begin
            mul_a = MA_W'(w_r);
            mul_b = K_CLEAR;
          end
          SQ_CLR_CMP: begin
            mul_a = MA_W'(sp_r);
            mul_b = MB_W'(cs_r);
          end
          SQ_DT100: begin
            mul_a = MA_W'(dt_r);
            mul_b = K_CENTI;
          end
          SQ_RATE: begin
            mul_a = MA_W'(hold[SW_W-1:0]);
            mul_b = prod[MB_W-1:0];
          end
          SQ_WCS: begin
            mul_a = MA_W'(w_r);
            mul_b = MB_W'(cs_r);
          end
          SQ_GAP: begin
            mul_a = MA_W'(screen_width);
            mul_b = MB_W'(cs_minus_sp);
          end
          SQ_SCALE: begin
            mul_a = hold2;
            mul_b = K_SAFE;
          end
          default: ;
        endcase
      end
      ST_PLACE: begin
        mul_a = MA_W'(lane);
        mul_b = MB_W'(pitch);
      end
      default: ;
    endcase
  end

  assign mul_full = FULL_W'(mul_a) * FULL_W'($signed({1'b0, mul_b}));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    lane_next  = lane;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (show_enable) begin
            state_next = ST_PITCH;
            step_next  = PS_RECIP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_PITCH: begin
        if (step == PS_FIX) begin
          state_next = ST_READ;
          lane_next  = '0;
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_READ: begin
        state_next = ST_TEST;
        step_next  = SQ_DT60;
      end
      ST_TEST: begin
        step_next = step + 4'd1;
        if ((step == SQ_CLR_CMP && !hold_gt_prod) ||
            (step == SQ_SAFE_CMP && !hold_gt_prod)) begin
          if (lane == LAST) begin
            state_next = ST_DONE;
          end else begin
            lane_next  = lane + AW'(1);
            state_next = ST_READ;
          end
        end else if ((step == SQ_CLR_CMP && !cs_gt_sp) || step == SQ_SAFE_CMP) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      lane    <= '0;
      step    <= '0;
      found_r <= 1'b0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
      step  <= step_next;
      if (accept) begin
        found_r <= 1'b0;
      end else if (state == ST_PLACE) begin
        found_r <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= req.now_ms;
      tw_r  <= req.text_width;
      cs_r  <= req.speed_q8;
    end
    if (state == ST_READ) begin
      dt_r <= dt_sat;
      w_r  <= w_eff;
      sp_r <= sp_eff;
    end
    if (mul_en) begin
      prod <= mul_full[PROD_W-1:0];
    end
    // The reciprocal estimate may fall one short; one compare fixes it.
    if (state == ST_PITCH) begin
      if (step == PS_BACK) begin
        pitch <= hi_q;
      end else if (step == PS_FIX && pitch_rem >= (DIM_W+1)'(LANES)) begin
        pitch <= pitch + DIM_W'(1);
      end
    end
    if (state == ST_TEST) begin
      if (step == SQ_WCLR || step == SQ_DT100 || step == SQ_WCS) begin
        hold <= prod;
      end
      if (step == SQ_GAP) begin
        hold2 <= prod[MA_W-1:0];
      end else if (step == SQ_SUM) begin
        hold2 <= hold2 + prod[MA_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found  <= found_r;
      out_lane   <= found_r ? LANE_W'(lane) : '0;
      out_lane_y <= found_r ? prod[DIM_W-1:0] : '0;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.found  = out_found;
  assign rsp.lane   = out_lane;
  assign rsp.lane_y = out_lane_y;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while a word is still in work");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.lane == '0 && rsp.lane_y == '0))
    else $error("unplaced result carries a lane or row");

  a_lane_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> ({1'b0, rsp.lane} < (LANE_W+1)'(LANES)))
    else $error("result lane beyond the lane count");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) |-> (step <= SQ_SAFE_CMP))
    else $error("lane test sequencer ran past its last step");

  a_place_marks_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |=> (found_r && state == ST_DONE && lane_valid[lane]))
    else $error("placed lane not recorded");

endmodule

`default_nettype wire

[test/tb_scroll_comment_lane_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scroll comment lane allocator testbench
// Drives comment requests through the request channel and checks every lane
// result against a lane-by-lane placement model kept in a scoreboard class.
// Register settings are changed over the APB port between phases and read
// back. The result side stalls on shifting patterns and twice for a long
// stretch, so that the block holds its word and stalls its input.
// ----------------------------------------------------------------------------

module tb_scroll_comment_lane_allocator;
  import scla_pkg::*;

  localparam int LANE_COUNT  = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  localparam longint FRAMES_PER_SEC = 60;
  localparam longint CLEAR_SCALE    = 256000;
  localparam longint CENTI          = 100;
  localparam longint SAFE_SCALE     = 426752;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic              found;
    logic [LANE_W-1:0] lane;
    logic [DIM_W-1:0]  lane_y;
  } placement_t;

  class lane_placement_board;
    logic [NOW_W-1:0] start_ms [LANE_COUNT];
    logic [SW_W-1:0]  width_px [LANE_COUNT];
    logic [SPD_W-1:0] speed    [LANE_COUNT];
    logic [DIM_W-1:0] scr_w;
    logic [DIM_W-1:0] scr_h;
    logic             show_en;
    placement_t       placements_due[$];
    int               errors;

    function new();
      for (int i = 0; i < LANE_COUNT; i++) begin
        start_ms[i] = START_RESET;
        width_px[i] = WIDTH_RESET;
        speed[i]    = SPEED_RESET;
      end
      scr_w   = SCREEN_WIDTH_RST;
      scr_h   = SCREEN_HEIGHT_RST;
      show_en = 1'b1;
      errors  = 0;
    endfunction

    function void set_config(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w = val[DIM_W-1:0];
        REG_SCREEN_HEIGHT: scr_h = val[DIM_W-1:0];
        REG_SHOW_ENABLE:   show_en = val[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_SCREEN_WIDTH:  return {18'd0, scr_w};
        REG_SCREEN_HEIGHT: return {18'd0, scr_h};
        REG_SHOW_ENABLE:   return {31'd0, show_en};
        default:           return 32'd0;
      endcase
    endfunction

    // The old comment must have cleared its own width at the new speed, and a
    // faster newcomer must not catch it before it leaves the screen.
    function bit lane_is_free(int i, logic [NOW_W-1:0] now, longint cs);
      logic [NOW_W-1:0] el;
      longint dt, w, sp, wr;
      el = now - start_ms[i];
      dt = longint'((el > NOW_W'(DT_MAX)) ? NOW_W'(DT_MAX) : el);
      w  = longint'($signed(width_px[i]));
      sp = longint'(speed[i]);
      wr = longint'(scr_w);
      if (!(dt * FRAMES_PER_SEC * cs > w * CLEAR_SCALE))
        return 1'b0;
      if (cs <= sp)
        return 1'b1;
      return (dt * sp * CENTI - w * SAFE_SCALE) * cs > wr * (cs - sp) * SAFE_SCALE;
    endfunction

    function void note_comment(logic [NOW_W-1:0] now, logic [TW_W-1:0] tw,
                               logic [SPD_W-1:0] cs);
      placement_t p;
      bit placed;
      p = '0;
      placed = 1'b0;
      if (show_en) begin
        for (int i = 0; i < LANE_COUNT && !placed; i++) begin
          if (lane_is_free(i, now, longint'(cs))) begin
            start_ms[i] = now;
            width_px[i] = {11'd0, tw};
            speed[i]    = cs;
            p.found     = 1'b1;
            p.lane      = LANE_W'(i);
            p.lane_y    = DIM_W'(i * (scr_h / LANE_COUNT));
            placed      = 1'b1;
          end
        end
      end
      placements_due.push_back(p);
    endfunction

    function void check_placement(logic found, logic [LANE_W-1:0] lane,
                                  logic [DIM_W-1:0] lane_y);
      placement_t p;
      if (placements_due.size() == 0) begin
        $error("unexpected result: found %0d lane %0d lane_y %0d", found, lane, lane_y);
        errors++;
        return;
      end
      p = placements_due.pop_front();
      if (found !== p.found) begin
        $error("found mismatch: expected %0d, actual %0d", p.found, found);
        errors++;
      end
      if (lane !== p.lane) begin
        $error("lane mismatch: expected %0d, actual %0d", p.lane, lane);
        errors++;
      end
      if (lane_y !== p.lane_y) begin
        $error("lane_y mismatch: expected %0d, actual %0d", p.lane_y, lane_y);
        errors++;
      end
    endfunction

    function int pending();
      return placements_due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  scla_req_if req_if ();
  scla_rsp_if rsp_if ();

  lane_placement_board sb;
  bit                  hold_start;
  int                  burst_left;
  logic [NOW_W-1:0]    clock_ms;

  scroll_comment_lane_allocator #(
    .LANES(LANE_COUNT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_if),
    .rsp     (rsp_if)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Every accepted request is predicted at once; only one word is in work and
  // the registers change only while the block is idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready)
        sb.note_comment(req_if.now_ms, req_if.text_width, req_if.speed_q8);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_placement(rsp_if.found, rsp_if.lane, rsp_if.lane_y);
    end
  end

  initial begin : rsp_driver
    rx_mode_t mode;
    int       mode_left;
    int       cyc;
    bit       r;
    rsp_if.ready = 1'b0;
    mode = RX_STEADY;
    mode_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        cyc++;
        case (mode)
          RX_STEADY:   r = 1'b1;
          RX_RANDOM:   r = 1'($urandom_range(0, 1));
          RX_PERIODIC: r = (cyc % 7) > 2;
          default:     r = ($urandom_range(0, 3) == 0);
        endcase
        rsp_if.ready <= r;
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_config(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.reg_value(idx)) begin
      $error("register %0d readback: expected %0h, actual %0h",
             idx, sb.reg_value(idx), prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    apb_read_check(REG_SCREEN_WIDTH);
    apb_read_check(REG_SCREEN_HEIGHT);
    apb_read_check(REG_SHOW_ENABLE);
  endtask

  task automatic configure(input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] en);
    apb_write(REG_SCREEN_WIDTH, w);
    apb_write(REG_SCREEN_HEIGHT, h);
    apb_write(REG_SHOW_ENABLE, en);
    check_regs();
  endtask

  // Returns at the clock edge that accepted the word, with valid still high.
  task automatic send_comment(input logic [NOW_W-1:0] now, input logic [TW_W-1:0] tw,
                              input logic [SPD_W-1:0] cs);
    req_if.valid      <= 1'b1;
    req_if.now_ms     <= now;
    req_if.text_width <= tw;
    req_if.speed_q8   <= cs;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly comments on an advancing clock, so that lanes fill and drain; the
  // rest is noise, backward time, zero speed, saturating jumps and extremes.
  task automatic draw_comment(input int unsigned step_max, output logic [NOW_W-1:0] now,
                              output logic [TW_W-1:0] tw, output logic [SPD_W-1:0] cs);
    int kind;
    kind = $urandom_range(0, 99);
    tw = TW_W'($urandom_range(16, 640));
    cs = SPD_W'($urandom_range(128, 1280));
    if (kind < 80) begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
      now = clock_ms;
    end else if (kind < 84) begin
      now = $urandom;
      tw  = TW_W'($urandom_range(0, 8191));
      cs  = SPD_W'($urandom_range(0, 4095));
    end else if (kind < 88) begin
      now = clock_ms - $urandom_range(1, 5000);
      cs  = SPD_W'($urandom_range(0, 4095));
    end else if (kind < 91) begin
      now = clock_ms;
      cs  = '0;
    end else if (kind < 94) begin
      clock_ms = clock_ms + $urandom_range(1048576, 4000000);
      now = clock_ms;
    end else if (kind < 97) begin
      clock_ms = clock_ms + $urandom_range(0, 50);
      now = clock_ms;
      tw  = $urandom_range(0, 1) ? '1 : '0;
      cs  = $urandom_range(0, 1) ? '1 : SPD_W'(1);
    end else begin
      now = clock_ms;
    end
  endtask

  task automatic run_phase(input int n_items, input int unsigned step_max, input bit hold);
    logic [NOW_W-1:0] now;
    logic [TW_W-1:0]  tw;
    logic [SPD_W-1:0] cs;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) begin
        req_if.valid <= 1'b0;
        wait_idle();
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 9) < 7) begin
          req_if.valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
      if (hold && k == 20)
        hold_start = 1'b1;
      draw_comment(step_max, now, tw, cs);
      send_comment(now, tw, cs);
      if (burst_left > 0)
        burst_left--;
    end
    req_if.valid <= 1'b0;
    wait_idle();
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.now_ms     = '0;
    req_if.text_width = '0;
    req_if.speed_q8   = '0;
    hold_start        = 1'b0;
    burst_left        = 0;
    clock_ms          = '0;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults after reset, then the directed cases.
    check_regs();
    send_comment('0, '0, '0);             // zero speed takes an empty lane
    send_comment('0, '1, '1);             // lane 0 not cleared, next empty lane
    send_comment('0, '0, '0);
    for (int i = 0; i < 21; i++)
      send_comment(32'd1000, '1, '1);     // fill every remaining lane
    send_comment(32'd1000, '0, SPD_W'(1)); // no free lane left
    send_comment('1, '1, '1);             // elapsed time saturates
    send_comment(32'd500, 13'd100, 12'd256); // time running backward
    req_if.valid <= 1'b0;
    wait_idle();

    clock_ms = 32'd10000;
    run_phase(250, 120, 1'b0);

    configure(32'd8192, 32'd8192, 32'd1);
    run_phase(200, 400, 1'b1);

    configure(32'd1, 32'd1, 32'd1);
    run_phase(200, 60, 1'b0);

    // Zero screen height puts every lane on row 0.
    configure(32'd16383, 32'd0, 32'd1);
    run_phase(150, 200, 1'b0);

    // Upper data bits are ignored, so bit 0 clear disables placement.
    configure(32'hFFFF_C064, 32'h5555_6AAA, 32'hFFFF_FFFE);
    run_phase(80, 100, 1'b0);

    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    check_regs();
    configure($urandom_range(1, 8192), $urandom_range(1, 8192), 32'd1);
    run_phase(200, 250, 1'b1);

    // The clock crosses the 32-bit wrap in this phase.
    clock_ms = 32'hFFFF_0000;
    configure(32'd1920, 32'd1080, 32'd1);
    run_phase(200, 150, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
src/scla_pkg.sv
src/scla_if.sv
src/scla_ram.sv
src/scroll_comment_lane_allocator.sv
test/tb_scroll_comment_lane_allocator.sv
